// ===== sv/csu_pkg.sv =====
// Shared types and constants for the comment stripper unit.
// Holds the lexer mode and held-prefix codes, byte constants and the burst record.
// No dependencies.
package csu_pkg;

	localparam int LINE_BITS_DEF   = 20;
	localparam int COLUMN_BITS_DEF = 16;

	// A single input item yields at most three results.
	localparam int BURST_DEPTH = 3;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_LINE,
		MODE_BLOCK,
		MODE_STRING,
		MODE_CHAR
	} mode_t;

	typedef enum logic [2:0] {
		HOLD_NONE,
		HOLD_SLASH,
		HOLD_STAR,
		HOLD_BSL,
		HOLD_BSL_CR
	} hold_t;

	// Results of one item: count entries, the last one is a status entry when status is set.
	typedef struct packed {
		logic [1:0]                  count;
		logic [BURST_DEPTH-1:0][7:0] bytes;
		logic                        status;
		logic                        open_err;
	} burst_t;

endpackage

// ===== sv/c_comment_stripper_unit.sv =====
// Top level of the comment stripper: input register, lexer step and result register.
// Depends on csu_pkg, csu_lexer and csu_burst.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------
//  text     | text_valid / text_stall    | text_byte, end_of_text
//  result   | result_valid / result_stall| out_byte, byte_valid, run_last,
//           |                            | open_comment_error, error_line, error_column
//
// An item waits in the input register until the result register is free; the lexer step
// then loads its results into the result register, from which the first result shows.
// An item with no results leaves the input side free; one with n results holds the result
// register, and thereby the input, for n transfers.
// Reset puts the lexer in normal mode with nothing held, at line 1, column 1.
// A stall on the result side backs up into text_stall once the input register is full.
module c_comment_stripper_unit #(
	parameter int LINE_BITS   = csu_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = csu_pkg::COLUMN_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   text_valid,
	output logic                   text_stall,
	input  logic [7:0]             text_byte,
	input  logic                   end_of_text,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [7:0]             out_byte,
	output logic                   byte_valid,
	output logic                   run_last,
	output logic                   open_comment_error,
	output logic [LINE_BITS-1:0]   error_line,
	output logic [COLUMN_BITS-1:0] error_column
);
	import csu_pkg::*;

	logic                   valid_s1;
	logic [7:0]             text_byte_s1;
	logic                   end_of_text_s1;
	logic                   free;
	logic                   advance;
	logic                   accept;
	burst_t                 burst;
	logic [LINE_BITS-1:0]   status_line;
	logic [COLUMN_BITS-1:0] status_column;

	assign advance    = valid_s1 && free;
	assign text_stall = valid_s1 && !free;
	assign accept     = text_valid && !text_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			text_byte_s1   <= text_byte;
			end_of_text_s1 <= end_of_text;
		end
	end

	csu_lexer #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_lexer (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.text_byte     (text_byte_s1),
		.end_of_text   (end_of_text_s1),
		.burst         (burst),
		.status_line   (status_line),
		.status_column (status_column)
	);

	csu_burst #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_burst (
		.clk                (clk),
		.arst_n             (arst_n),
		.load               (advance),
		.burst              (burst),
		.status_line        (status_line),
		.status_column      (status_column),
		.result_stall       (result_stall),
		.free               (free),
		.result_valid       (result_valid),
		.out_byte           (out_byte),
		.byte_valid         (byte_valid),
		.run_last           (run_last),
		.open_comment_error (open_comment_error),
		.error_line         (error_line),
		.error_column       (error_column)
	);

`ifndef ASSERT_OFF
	// The input side only stalls while an item waits in the input register.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> valid_s1)
		else $error("text_stall raised with an empty input register");

	// The end status always closes its item's run of results.
	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !byte_valid) |-> run_last)
		else $error("status result not marked as the last of its item");

	// Line numbers start at one, so a reported line is never zero.
	a_status_line: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !byte_valid) |-> (error_line != '0 && error_column != '0))
		else $error("status result carries a zero line or column");

	// A kept byte never carries status information.
	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && byte_valid) |-> (!open_comment_error && error_line == '0))
		else $error("byte result carries status fields");
`endif

endmodule

// ===== sv/csu_lexer.sv =====
// Lexer state and the combinational step that turns one input item into a burst.
// Depends on csu_pkg for modes, held-prefix codes, byte constants and burst_t.
module csu_lexer #(
	parameter int LINE_BITS   = csu_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = csu_pkg::COLUMN_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             text_byte,
	input  logic                   end_of_text,
	output csu_pkg::burst_t        burst,
	output logic [LINE_BITS-1:0]   status_line,
	output logic [COLUMN_BITS-1:0] status_column
);
	import csu_pkg::*;

	typedef struct packed {
		hold_t hold;
		mode_t mode;
		logic  emit;
		logic  inc;
		logic  nl;
	} fresh_t;

	// Handling of a byte when nothing is held in front of it.
	function automatic fresh_t fresh_f(input mode_t m, input logic [7:0] c);
		fresh_t r;
		r.hold = HOLD_NONE;
		r.mode = m;
		r.emit = 1'b0;
		r.inc  = 1'b0;
		r.nl   = 1'b0;
		if (c == CH_BSL) begin
			r.hold = HOLD_BSL;
		end else begin
			case (m)
				MODE_NORMAL: begin
					if (c == CH_SLASH) begin
						r.hold = HOLD_SLASH;
					end else begin
						r.emit = 1'b1;
						if (c == CH_DQUOTE) begin
							r.mode = MODE_STRING;
						end else if (c == CH_SQUOTE) begin
							r.mode = MODE_CHAR;
						end
						r.nl  = (c == CH_LF);
						r.inc = (c != CH_LF);
					end
				end
				MODE_LINE: begin
					if (c == CH_LF) begin
						r.emit = 1'b1;
						r.mode = MODE_NORMAL;
						r.nl   = 1'b1;
					end else begin
						r.inc = 1'b1;
					end
				end
				MODE_BLOCK: begin
					if (c == CH_STAR) begin
						r.hold = HOLD_STAR;
					end else begin
						r.nl  = (c == CH_LF);
						r.inc = (c != CH_LF);
					end
				end
				MODE_STRING, MODE_CHAR: begin
					r.emit = 1'b1;
					if ((m == MODE_STRING && c == CH_DQUOTE) ||
					    (m == MODE_CHAR && c == CH_SQUOTE)) begin
						r.mode = MODE_NORMAL;
						r.inc  = 1'b1;
					end else begin
						r.nl  = (c == CH_LF);
						r.inc = (c != CH_LF);
					end
				end
				default: begin
				end
			endcase
		end
		return r;
	endfunction

	localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [COLUMN_BITS+1:0] COL_MAX  = {2'b00, {COLUMN_BITS{1'b1}}};

	mode_t                   mode_q;
	hold_t                   hold_q;
	logic [LINE_BITS-1:0]    line_q;
	logic [COLUMN_BITS-1:0]  col_q;

	mode_t                   mode_n;
	hold_t                   hold_n;
	logic [LINE_BITS-1:0]    line_n;
	logic [COLUMN_BITS-1:0]  col_n;
	fresh_t                  fr;
	logic                    use_fresh;
	logic                    keeps;
	logic                    lit;
	logic [1:0]              pc;
	logic [7:0]              pb0;
	logic [7:0]              pb1;
	logic [1:0]              pinc;
	logic                    nl_pre;
	logic                    fe;
	logic                    finc;
	logic                    nl;
	logic [1:0]              inc_total;
	logic [COLUMN_BITS+1:0]  col_sum;
	logic [COLUMN_BITS-1:0]  col_sat;

	always_comb begin
		fr        = fresh_f(mode_q, text_byte);
		keeps     = (mode_q == MODE_NORMAL) || (mode_q == MODE_STRING) ||
		            (mode_q == MODE_CHAR);
		lit       = (mode_q == MODE_STRING) || (mode_q == MODE_CHAR);
		use_fresh = 1'b0;
		pc        = 2'd0;
		pb0       = CH_BSL;
		pb1       = CH_CR;
		pinc      = 2'd0;
		nl_pre    = 1'b0;
		mode_n    = mode_q;
		hold_n    = HOLD_NONE;
		if (end_of_text) begin
			// Flush whatever is held as if the text ended here.
			case (hold_q)
				HOLD_SLASH: begin
					pc   = 2'd1;
					pb0  = CH_SLASH;
					pinc = 2'd1;
				end
				HOLD_STAR: begin
					pinc = 2'd1;
				end
				HOLD_BSL: begin
					if (keeps) begin
						pc = 2'd1;
					end
					pinc = 2'd1;
				end
				HOLD_BSL_CR: begin
					if (keeps) begin
						pc = 2'd2;
					end
					pinc = 2'd2;
				end
				default: begin
				end
			endcase
		end else begin
			case (hold_q)
				HOLD_BSL: begin
					if (text_byte == CH_LF) begin
						nl_pre = 1'b1;
					end else if (text_byte == CH_CR) begin
						hold_n = HOLD_BSL_CR;
					end else if (lit) begin
						// Escape pair: both bytes kept, the literal stays open.
						pc   = 2'd2;
						pb1  = text_byte;
						pinc = 2'd2;
					end else begin
						if (mode_q == MODE_NORMAL) begin
							pc = 2'd1;
						end
						pinc      = 2'd1;
						use_fresh = 1'b1;
					end
				end
				HOLD_BSL_CR: begin
					if (text_byte == CH_LF) begin
						nl_pre = 1'b1;
					end else begin
						if (keeps) begin
							pc = 2'd2;
						end
						pinc      = 2'd2;
						use_fresh = 1'b1;
					end
				end
				HOLD_SLASH: begin
					if (text_byte == CH_SLASH) begin
						mode_n = MODE_LINE;
						pinc   = 2'd2;
					end else if (text_byte == CH_STAR) begin
						mode_n = MODE_BLOCK;
						pinc   = 2'd2;
					end else begin
						pc        = 2'd1;
						pb0       = CH_SLASH;
						pinc      = 2'd1;
						use_fresh = 1'b1;
					end
				end
				HOLD_STAR: begin
					if (text_byte == CH_SLASH) begin
						mode_n = MODE_NORMAL;
						pinc   = 2'd2;
					end else begin
						pinc      = 2'd1;
						use_fresh = 1'b1;
					end
				end
				default: begin
					use_fresh = 1'b1;
				end
			endcase
		end

		fe   = 1'b0;
		finc = 1'b0;
		nl   = nl_pre;
		if (use_fresh) begin
			hold_n = fr.hold;
			mode_n = fr.mode;
			fe     = fr.emit;
			finc   = fr.inc;
			nl     = nl_pre | fr.nl;
		end

		inc_total = pinc + {1'b0, finc};
		col_sum   = {2'b00, col_q} + {{COLUMN_BITS{1'b0}}, inc_total};
		col_sat   = (col_sum > COL_MAX) ? {COLUMN_BITS{1'b1}} : col_sum[COLUMN_BITS-1:0];

		if (nl) begin
			col_n  = COLUMN_BITS'(1);
			line_n = (line_q != LINE_MAX) ? line_q + LINE_BITS'(1) : line_q;
		end else begin
			col_n  = col_sat;
			line_n = line_q;
		end

		burst.count    = end_of_text ? pc + 2'd1 : pc + {1'b0, fe};
		burst.bytes[0] = (pc != 2'd0) ? pb0 : text_byte;
		burst.bytes[1] = (pc == 2'd2) ? pb1 : text_byte;
		burst.bytes[2] = text_byte;
		burst.status   = end_of_text;
		burst.open_err = (mode_q == MODE_BLOCK);
		status_line    = line_q;
		status_column  = col_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			hold_q <= HOLD_NONE;
			line_q <= LINE_BITS'(1);
			col_q  <= COLUMN_BITS'(1);
		end else if (step) begin
			if (end_of_text) begin
				mode_q <= MODE_NORMAL;
				hold_q <= HOLD_NONE;
				line_q <= LINE_BITS'(1);
				col_q  <= COLUMN_BITS'(1);
			end else begin
				mode_q <= mode_n;
				hold_q <= hold_n;
				line_q <= line_n;
				col_q  <= col_n;
			end
		end
	end

endmodule

// ===== sv/csu_burst.sv =====
// Result register that holds one item's burst and hands it out one result per transfer.
// Depends on csu_pkg for burst_t.
module csu_burst #(
	parameter int LINE_BITS   = csu_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = csu_pkg::COLUMN_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  csu_pkg::burst_t        burst,
	input  logic [LINE_BITS-1:0]   status_line,
	input  logic [COLUMN_BITS-1:0] status_column,
	input  logic                   result_stall,
	output logic                   free,
	output logic                   result_valid,
	output logic [7:0]             out_byte,
	output logic                   byte_valid,
	output logic                   run_last,
	output logic                   open_comment_error,
	output logic [LINE_BITS-1:0]   error_line,
	output logic [COLUMN_BITS-1:0] error_column
);
	import csu_pkg::*;

	logic [1:0]                  cnt_q;
	logic [1:0]                  pos_q;
	logic [BURST_DEPTH-1:0][7:0] bytes_q;
	logic                        status_q;
	logic                        err_q;
	logic [LINE_BITS-1:0]        line_q;
	logic [COLUMN_BITS-1:0]      col_q;

	logic last;
	logic take;
	logic is_stat;

	always_comb begin
		result_valid       = (cnt_q != 2'd0);
		last               = (pos_q == cnt_q - 2'd1);
		take               = result_valid && !result_stall;
		free               = !result_valid || (take && last);
		is_stat            = status_q && last;
		out_byte           = is_stat ? 8'd0 : bytes_q[pos_q];
		byte_valid         = !is_stat;
		run_last           = last;
		open_comment_error = is_stat && err_q;
		error_line         = is_stat ? line_q : '0;
		error_column       = is_stat ? col_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			pos_q <= 2'd0;
		end else if (load) begin
			cnt_q <= burst.count;
			pos_q <= 2'd0;
		end else if (take) begin
			if (last) begin
				cnt_q <= 2'd0;
				pos_q <= 2'd0;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q  <= burst.bytes;
			status_q <= burst.status;
			err_q    <= burst.open_err;
			line_q   <= status_line;
			col_q    <= status_column;
		end
	end

endmodule

// ===== verif/tb.sv =====
// Testbench for c_comment_stripper_unit: directed and random C text in, stripped bytes out.
// Depends on csu_pkg and the RTL of the unit; expected results come from a lexer model here.
module tb;
	import csu_pkg::*;

	localparam int LINE_W = LINE_BITS_DEF;
	localparam int COL_W = COLUMN_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 10;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [7:0] data;
		logic eot;
	} text_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic valid;
		logic last;
		logic open_err;
		logic [LINE_W-1:0] line;
		logic [COL_W-1:0] column;
	} strip_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic text_valid = 1'b0;
	logic text_stall;
	logic [7:0] text_byte = '0;
	logic end_of_text = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [7:0] out_byte;
	logic byte_valid;
	logic run_last;
	logic open_comment_error;
	logic [LINE_W-1:0] error_line;
	logic [COL_W-1:0] error_column;

	c_comment_stripper_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.run_last(run_last),
		.open_comment_error(open_comment_error),
		.error_line(error_line),
		.error_column(error_column)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	text_item_t source_q[$];
	text_item_t next_item;
	strip_result_t stripped_q[$];
	strip_result_t burst[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int queued_count = 0;
	int text_count = 0;
	int texts_done = 0;
	int result_count = 0;
	int mismatch_count = 0;
	int idle_cycles = 0;
	int hold_left = 0;
	int hold_at = 0;
	bit hold_armed = 1'b0;
	bit hold_done = 1'b0;

	// Lexer state of the expected-result model.
	mode_t lx_mode = MODE_NORMAL;
	hold_t lx_hold = HOLD_NONE;
	logic [LINE_W-1:0] lx_line = LINE_W'(1);
	logic [COL_W-1:0] lx_col = COL_W'(1);

	function automatic void next_col();
		if (lx_col != '1)
			lx_col = lx_col + COL_W'(1);
	endfunction

	function automatic void next_line();
		if (lx_line != '1)
			lx_line = lx_line + LINE_W'(1);
		lx_col = COL_W'(1);
	endfunction

	function automatic void keep_byte(logic [7:0] c);
		strip_result_t r;
		r = '0;
		r.data = c;
		r.valid = 1'b1;
		burst.push_back(r);
	endfunction

	function automatic bit lx_keeps();
		return lx_mode == MODE_NORMAL || lx_mode == MODE_STRING || lx_mode == MODE_CHAR;
	endfunction

	function automatic string show(logic [7:0] b, logic v, logic l, logic e,
			logic [LINE_W-1:0] ln, logic [COL_W-1:0] cl);
		return $sformatf("byte %02h valid %0b last %0b open %0b line %0d col %0d",
			b, v, l, e, ln, cl);
	endfunction

	// A byte seen with nothing held from the previous one.
	function automatic void lex_fresh(logic [7:0] c);
		if (c == CH_BSL) begin
			lx_hold = HOLD_BSL;
			return;
		end
		case (lx_mode)
			MODE_NORMAL: begin
				if (c == CH_SLASH) begin
					lx_hold = HOLD_SLASH;
					return;
				end
				keep_byte(c);
				if (c == CH_DQUOTE)
					lx_mode = MODE_STRING;
				else if (c == CH_SQUOTE)
					lx_mode = MODE_CHAR;
				if (c == CH_LF)
					next_line();
				else
					next_col();
			end
			MODE_LINE: begin
				if (c == CH_LF) begin
					keep_byte(c);
					lx_mode = MODE_NORMAL;
					next_line();
				end else begin
					next_col();
				end
			end
			MODE_BLOCK: begin
				if (c == CH_STAR) begin
					lx_hold = HOLD_STAR;
					return;
				end
				if (c == CH_LF)
					next_line();
				else
					next_col();
			end
			default: begin
				keep_byte(c);
				if ((lx_mode == MODE_STRING && c == CH_DQUOTE) ||
						(lx_mode == MODE_CHAR && c == CH_SQUOTE)) begin
					lx_mode = MODE_NORMAL;
					next_col();
				end else if (c == CH_LF) begin
					next_line();
				end else begin
					next_col();
				end
			end
		endcase
	endfunction

	function automatic void lex_take(logic [7:0] c);
		hold_t h;
		h = lx_hold;
		lx_hold = HOLD_NONE;
		case (h)
			HOLD_BSL: begin
				if (c == CH_LF) begin
					next_col();
					next_line();
				end else if (c == CH_CR) begin
					lx_hold = HOLD_BSL_CR;
				end else if (lx_mode == MODE_STRING || lx_mode == MODE_CHAR) begin
					// Escape pair inside a literal: both bytes kept, neither ends it.
					keep_byte(CH_BSL);
					keep_byte(c);
					next_col();
					next_col();
				end else begin
					if (lx_mode == MODE_NORMAL)
						keep_byte(CH_BSL);
					next_col();
					lex_fresh(c);
				end
			end
			HOLD_BSL_CR: begin
				if (c == CH_LF) begin
					next_col();
					next_line();
				end else begin
					if (lx_keeps()) begin
						keep_byte(CH_BSL);
						keep_byte(CH_CR);
					end
					next_col();
					next_col();
					lex_fresh(c);
				end
			end
			HOLD_SLASH: begin
				if (c == CH_SLASH || c == CH_STAR) begin
					if (c == CH_SLASH)
						lx_mode = MODE_LINE;
					else
						lx_mode = MODE_BLOCK;
					next_col();
					next_col();
				end else begin
					keep_byte(CH_SLASH);
					next_col();
					lex_fresh(c);
				end
			end
			HOLD_STAR: begin
				if (c == CH_SLASH) begin
					lx_mode = MODE_NORMAL;
					next_col();
					next_col();
				end else begin
					next_col();
					lex_fresh(c);
				end
			end
			default: lex_fresh(c);
		endcase
	endfunction

	function automatic void lex_flush();
		hold_t h;
		h = lx_hold;
		lx_hold = HOLD_NONE;
		case (h)
			HOLD_SLASH: begin
				keep_byte(CH_SLASH);
				next_col();
			end
			HOLD_STAR: next_col();
			HOLD_BSL: begin
				if (lx_keeps())
					keep_byte(CH_BSL);
				next_col();
			end
			HOLD_BSL_CR: begin
				if (lx_keeps()) begin
					keep_byte(CH_BSL);
					keep_byte(CH_CR);
				end
				next_col();
				next_col();
			end
			default: ;
		endcase
	endfunction

	// Works out the results of one accepted text item and appends them to stripped_q.
	function automatic void strip_predict(logic [7:0] c, logic eot);
		strip_result_t r;
		burst.delete();
		if (eot) begin
			lex_flush();
			r = '0;
			r.open_err = (lx_mode == MODE_BLOCK);
			r.line = lx_line;
			r.column = lx_col;
			burst.push_back(r);
			lx_mode = MODE_NORMAL;
			lx_hold = HOLD_NONE;
			lx_line = LINE_W'(1);
			lx_col = COL_W'(1);
		end else begin
			lex_take(c);
		end
		if (burst.size() != 0)
			burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i])
			stripped_q.push_back(burst[i]);
	endfunction

	function automatic logic [7:0] noise_byte();
		if ($urandom_range(1) == 0)
			return 8'($urandom_range(255));
		case ($urandom_range(6))
			0: return CH_SLASH;
			1: return CH_STAR;
			2: return CH_DQUOTE;
			3: return CH_SQUOTE;
			4: return CH_BSL;
			5: return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] body_byte();
		if ($urandom_range(9) < 7)
			return 8'($urandom_range(97, 122));
		return noise_byte();
	endfunction

	task automatic queue_byte(input logic [7:0] b);
		text_item_t item;
		item.data = b;
		item.eot = 1'b0;
		source_q.push_back(item);
		queued_count++;
	endtask

	task automatic queue_end();
		text_item_t item;
		item.data = 8'($urandom_range(255));
		item.eot = 1'b1;
		source_q.push_back(item);
		queued_count++;
	endtask

	task automatic queue_string(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i]);
	endtask

	// One lexical piece: mostly well-formed comments, literals and continuations.
	task automatic queue_fragment();
		int n;
		case ($urandom_range(9))
			0, 1: begin
				n = $urandom_range(1, 4);
				repeat (n) queue_byte(noise_byte());
			end
			2: begin
				queue_byte(CH_SLASH);
				queue_byte(CH_SLASH);
				repeat ($urandom_range(4)) queue_byte(body_byte());
				if ($urandom_range(3) == 0) begin
					queue_byte(CH_BSL);
					queue_byte(CH_LF);
					queue_byte(body_byte());
				end
				queue_byte(CH_LF);
			end
			3: begin
				queue_byte(CH_SLASH);
				queue_byte(CH_STAR);
				repeat ($urandom_range(5)) begin
					n = $urandom_range(5);
					if (n == 0)
						queue_byte(CH_STAR);
					else if (n == 1)
						queue_byte(CH_LF);
					else
						queue_byte(body_byte());
				end
				queue_byte(CH_STAR);
				queue_byte(CH_SLASH);
			end
			4: begin
				queue_byte(CH_DQUOTE);
				repeat ($urandom_range(4)) begin
					if ($urandom_range(3) == 0)
						queue_byte(CH_BSL);
					queue_byte(body_byte());
				end
				queue_byte(CH_DQUOTE);
			end
			5: begin
				queue_byte(CH_SQUOTE);
				if ($urandom_range(1) == 0) begin
					queue_byte(CH_BSL);
					queue_byte(($urandom_range(1) == 0) ? CH_SQUOTE : body_byte());
				end else begin
					queue_byte(body_byte());
				end
				queue_byte(CH_SQUOTE);
			end
			6: begin
				queue_byte(CH_BSL);
				if ($urandom_range(1) == 0)
					queue_byte(CH_CR);
				queue_byte(CH_LF);
			end
			7: begin
				queue_byte(CH_BSL);
				queue_byte(CH_CR);
				queue_byte(noise_byte());
			end
			8: begin
				n = $urandom_range(1, 5);
				repeat (n) queue_byte(8'($urandom_range(97, 122)));
				if ($urandom_range(1) == 0)
					queue_byte(CH_LF);
			end
			default: begin
				queue_byte(($urandom_range(1) == 0) ? CH_SLASH : CH_STAR);
				queue_byte(body_byte());
			end
		endcase
	endtask

	task automatic queue_random(input int count);
		int target;
		target = queued_count + count;
		while (queued_count < target) begin
			repeat ($urandom_range(2, 10)) queue_fragment();
			queue_end();
		end
	endtask

	task automatic queue_directed();
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_string("/x//c\n/**\\");
		queue_byte(CH_CR);
		queue_string("\n*/\"\\\"\"\\");
		// Backslash and CR with no LF after them: three kept bytes from one item.
		queue_byte(CH_CR);
		queue_string("z");
		queue_end();
		queue_string("/*");
		queue_end();
		queue_string("'\\");
		queue_end();
	endtask

	task automatic drain();
		while (source_q.size() != 0 || text_valid || stripped_q.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid <= 1'b0;
			text_byte <= '0;
			end_of_text <= 1'b0;
		end else if (!text_valid || !text_stall) begin
			if (source_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = source_q.pop_front();
				text_valid <= 1'b1;
				text_byte <= next_item.data;
				end_of_text <= next_item.eot;
			end else begin
				text_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off so the unit fills up and pushes back on its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_armed && !hold_done && text_count >= hold_at) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_stall <= 1'b0;
		else
			result_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		strip_result_t want;
		if (arst_n) begin
			if (text_valid && !text_stall) begin
				text_count++;
				if (end_of_text)
					texts_done++;
				strip_predict(text_byte, end_of_text);
			end
			if (result_valid && !result_stall) begin
				result_count++;
				if (stripped_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected result: %s", show(out_byte, byte_valid,
							run_last, open_comment_error, error_line, error_column));
				end else begin
					want = stripped_q.pop_front();
					if (out_byte !== want.data || byte_valid !== want.valid ||
							run_last !== want.last || open_comment_error !== want.open_err ||
							error_line !== want.line || error_column !== want.column) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							$display("mismatch at result %0d: expected %s", result_count,
								show(want.data, want.valid, want.last, want.open_err,
								want.line, want.column));
							$display("  actual: %s", show(out_byte, byte_valid, run_last,
								open_comment_error, error_line, error_column));
						end
					end
				end
			end
			if ((text_valid && !text_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(negedge clk);
		$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("tb failed");
		$finish;
	end

	initial begin
		bit failed;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 11;
		recv_idle_pct = 79;
		queue_directed();
		queue_random(85);
		drain();

		send_idle_pct = 79;
		recv_idle_pct = 11;
		queue_random(85);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_at = text_count + 40;
		hold_armed = 1'b1;
		queue_random(85);
		drain();

		repeat (TAIL_CYCLES) @(negedge clk);
		failed = (mismatch_count != 0) || (stripped_q.size() != 0);
		if (stripped_q.size() != 0)
			$display("%0d expected results never arrived", stripped_q.size());
		$display("run: %0d text items in %0d texts, %0d results checked, %0d mismatches",
			text_count, texts_done, result_count, mismatch_count);
		$display("run: comments, literals, escapes, continuations and input and output stalls");
		if (!failed)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
